// ===== rtl/core/scpb_pkg.sv =====
package scpb_pkg;

   localparam int PKT_BODY_MAX = 17;
   localparam int IDX_W = $clog2(PKT_BODY_MAX + 1);

   typedef enum logic [2:0] {
      OP_PING      = 3'd0,
      OP_SET_LIMIT = 3'd1,
      OP_WRITE     = 3'd2,
      OP_REG_WRITE = 3'd3,
      OP_ACTION    = 3'd4,
      OP_SYNC_TWO  = 3'd5
   } op_type;

   localparam logic [7:0] HEADER_BYTE    = 8'hFF;
   localparam logic [7:0] BROADCAST_ID   = 8'hFE;
   localparam logic [7:0] INS_PING       = 8'h01;
   localparam logic [7:0] INS_WRITE      = 8'h03;
   localparam logic [7:0] INS_REG_WRITE  = 8'h04;
   localparam logic [7:0] INS_ACTION     = 8'h05;
   localparam logic [7:0] INS_SYNC_WRITE = 8'h83;
   localparam logic [7:0] ADDR_CW_LIMIT  = 8'h06;
   localparam logic [7:0] ADDR_GOAL      = 8'h1E;
   localparam logic [7:0] LEN_SHORT      = 8'd2;
   localparam logic [7:0] LEN_WRITE      = 8'd7;
   localparam logic [7:0] LEN_SYNC       = 8'd14;
   localparam logic [7:0] SYNC_DATA_LEN  = 8'd4;
   localparam logic [15:0] CLAMP_MAX     = 16'd1023;

   localparam logic [IDX_W-1:0] BODY_LEN_SHORT = IDX_W'(5);
   localparam logic [IDX_W-1:0] BODY_LEN_WRITE = IDX_W'(10);
   localparam logic [IDX_W-1:0] BODY_LEN_SYNC  = IDX_W'(17);

   typedef struct packed {
      logic [IDX_W-1:0]                   body_len;
      logic [PKT_BODY_MAX-1:0][7:0]       pkt_bytes;
   } pkt_desc_type;

   function automatic logic [15:0] clamp10(input logic [15:0] v);
      clamp10 = (v > CLAMP_MAX) ? CLAMP_MAX : v;
   endfunction

endpackage

// ===== rtl/core/scpb_front.sv =====
module scpb_front (
   input  logic [2:0]            req_operation,
   input  logic [7:0]            req_servo_id,
   input  logic [15:0]           req_position_or_cw_limit,
   input  logic [15:0]           req_speed_or_ccw_limit,
   input  logic [7:0]            req_second_servo_id,
   input  logic [15:0]           req_second_position,
   input  logic [15:0]           req_second_speed,
   output logic                  known_op,
   output scpb_pkg::pkt_desc_type desc
);
   import scpb_pkg::*;

   logic [15:0] a_clamped;
   logic [15:0] b_clamped;

   assign a_clamped = clamp10(req_position_or_cw_limit);
   assign b_clamped = clamp10(req_speed_or_ccw_limit);

   always_comb begin
      known_op       = 1'b1;
      desc.body_len  = BODY_LEN_SHORT;
      desc.pkt_bytes = '0;
      desc.pkt_bytes[0] = HEADER_BYTE;
      desc.pkt_bytes[1] = HEADER_BYTE;
      case (req_operation)
         OP_PING: begin
            desc.pkt_bytes[2] = req_servo_id;
            desc.pkt_bytes[3] = LEN_SHORT;
            desc.pkt_bytes[4] = INS_PING;
         end
         OP_SET_LIMIT, OP_WRITE: begin
            desc.body_len     = BODY_LEN_WRITE;
            desc.pkt_bytes[2] = req_servo_id;
            desc.pkt_bytes[3] = LEN_WRITE;
            desc.pkt_bytes[4] = INS_WRITE;
            desc.pkt_bytes[5] = (req_operation == OP_SET_LIMIT) ? ADDR_CW_LIMIT : ADDR_GOAL;
            desc.pkt_bytes[6] = a_clamped[7:0];
            desc.pkt_bytes[7] = a_clamped[15:8];
            desc.pkt_bytes[8] = b_clamped[7:0];
            desc.pkt_bytes[9] = b_clamped[15:8];
         end
         OP_REG_WRITE: begin
            desc.body_len     = BODY_LEN_WRITE;
            desc.pkt_bytes[2] = req_servo_id;
            desc.pkt_bytes[3] = LEN_WRITE;
            desc.pkt_bytes[4] = INS_REG_WRITE;
            desc.pkt_bytes[5] = ADDR_GOAL;
            desc.pkt_bytes[6] = req_position_or_cw_limit[7:0];
            desc.pkt_bytes[7] = req_position_or_cw_limit[15:8];
            desc.pkt_bytes[8] = req_speed_or_ccw_limit[7:0];
            desc.pkt_bytes[9] = req_speed_or_ccw_limit[15:8];
         end
         OP_ACTION: begin
            desc.pkt_bytes[2] = BROADCAST_ID;
            desc.pkt_bytes[3] = LEN_SHORT;
            desc.pkt_bytes[4] = INS_ACTION;
         end
         OP_SYNC_TWO: begin
            desc.body_len      = BODY_LEN_SYNC;
            desc.pkt_bytes[2]  = BROADCAST_ID;
            desc.pkt_bytes[3]  = LEN_SYNC;
            desc.pkt_bytes[4]  = INS_SYNC_WRITE;
            desc.pkt_bytes[5]  = ADDR_GOAL;
            desc.pkt_bytes[6]  = SYNC_DATA_LEN;
            desc.pkt_bytes[7]  = req_servo_id;
            desc.pkt_bytes[8]  = req_position_or_cw_limit[7:0];
            desc.pkt_bytes[9]  = req_position_or_cw_limit[15:8];
            desc.pkt_bytes[10] = req_speed_or_ccw_limit[7:0];
            desc.pkt_bytes[11] = req_speed_or_ccw_limit[15:8];
            desc.pkt_bytes[12] = req_second_servo_id;
            desc.pkt_bytes[13] = req_second_position[7:0];
            desc.pkt_bytes[14] = req_second_position[15:8];
            desc.pkt_bytes[15] = req_second_speed[7:0];
            desc.pkt_bytes[16] = req_second_speed[15:8];
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/scpb_queue.sv =====
module scpb_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  scpb_pkg::pkt_desc_type push_desc,
   input  logic                   pop,
   output logic                   full,
   output logic                   empty,
   output scpb_pkg::pkt_desc_type head
);
   import scpb_pkg::*;

   pkt_desc_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/scpb_back.sv =====
module scpb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  scpb_pkg::pkt_desc_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_packet_byte,
   output logic                   rsp_last_byte
);
   import scpb_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             advance;
   logic             fire;
   logic             at_checksum;
   logic [7:0]       body_byte;

   assign advance     = !rsp_valid_ff || rsp_ready;
   assign fire        = advance && !empty;
   assign at_checksum = (idx_ff >= head.body_len);
   assign body_byte   = head.pkt_bytes[idx_ff[IDX_W-1:0]];
   assign pop         = fire && at_checksum;

   always_comb begin
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rsp_valid_in = advance ? 1'b0 : rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (at_checksum) begin
            byte_in = ~sum_ff;
            last_in = 1'b1;
            idx_in  = '0;
            sum_in  = 8'd0;
         end else begin
            byte_in = body_byte;
            last_in = 1'b0;
            idx_in  = idx_ff + IDX_W'(1);
            if (idx_ff >= IDX_W'(2)) begin
               sum_in = sum_ff + body_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         sum_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packet_byte = byte_ff;
   assign rsp_last_byte   = last_ff;

endmodule

// ===== rtl/core/servo_command_packet_builder_core.sv =====
// An accepted command is first written into the command queue; its first packet byte is then
// registered in the back end's output register. Throughput: one packet byte per cycle while
// rsp_ready holds; a packet has 6 bytes for ping and action, 11 for writes, 18 for sync.
// The byte sequencer in the back end emits them, ending with the checksum byte.
// Reset (synchronous, active high) empties the command queue and the output.
module servo_command_packet_builder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_servo_id,
   input  logic [15:0] req_position_or_cw_limit,
   input  logic [15:0] req_speed_or_ccw_limit,
   input  logic [7:0]  req_second_servo_id,
   input  logic [15:0] req_second_position,
   input  logic [15:0] req_second_speed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_packet_byte,
   output logic        rsp_last_byte
);
   import scpb_pkg::*;

   pkt_desc_type front_desc;
   pkt_desc_type q_head;
   logic         known_op;
   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_empty;

   scpb_front u_front (
      .req_operation            (req_operation),
      .req_servo_id             (req_servo_id),
      .req_position_or_cw_limit (req_position_or_cw_limit),
      .req_speed_or_ccw_limit   (req_speed_or_ccw_limit),
      .req_second_servo_id      (req_second_servo_id),
      .req_second_position      (req_second_position),
      .req_second_speed         (req_second_speed),
      .known_op                 (known_op),
      .desc                     (front_desc)
   );

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready && known_op;

   scpb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (front_desc),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   scpb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (q_empty),
      .head            (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue pushed while full");

   a_last_on_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_valid && rsp_last_byte))
      else $error("checksum byte not marked last after packet end");

endmodule
